// ----- hdl/nearest_centroid_classifier_unit_assert.svh -----
// assertion helpers for the nearest centroid classifier
`ifndef NEAREST_CENTROID_CLASSIFIER_UNIT_ASSERT_SVH
`define NEAREST_CENTROID_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk and gated by rst_n
`define NCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest centroid check failed");

// next-cycle implication, checked on clk and gated by rst_n
`define NCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest centroid check failed");

`endif

// ----- hdl/ncc_pkg.sv -----
package ncc_pkg;

    localparam int COORD_W = 16;
    localparam int MAG_W   = 16;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 36;
    localparam int TOTAL_W = 39;
    localparam int CFG_W   = 4;
    localparam int OUT_K_W = 3;

    localparam logic [CFG_W-1:0] CLUSTERS_RESET = 4'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [2:0]                cluster_slot;
        logic [3:0]                dim_slot;
        logic signed [COORD_W-1:0] coord;
        logic                      last_coord;
    } in_item_t;

    typedef struct packed {
        logic [OUT_K_W-1:0] nearest_cluster;
        logic [DIST_W-1:0]  nearest_distance;
        logic [TOTAL_W-1:0] total_distance;
        logic               dims_overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_DONE
    } ncc_state_t;

endpackage

// ----- hdl/nearest_centroid_classifier_unit.sv -----
// load beat: written into the table as it is accepted; point coordinate: input stalls while one shared
// subtract / square / accumulate pipe visits every centroid in turn
// coordinate past the table depth: sets the overflow flag; last coordinate adds a scan of
// clusters_in_use centroids through one compare / add unit, result valid as the unit frees
// rst_n is asynchronous and active low: accumulators, position, overflow flag cleared,
// clusters_in_use = 3; centroid table is not cleared and holds garbage until loaded
module nearest_centroid_classifier_unit #(
    parameter int MAX_CLUSTERS = 8,
    parameter int MAX_DIMS     = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write channel (clusters_in_use)
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [3:0]                cfg_data,
    // item input
    input  logic                      in_valid,
    output logic                      in_stall,
    input  ncc_pkg::in_item_t         in_data,
    // result output
    output logic                      out_valid,
    input  logic                      out_stall,
    output ncc_pkg::out_item_t        out_data
);
    import ncc_pkg::*;

    `include "nearest_centroid_classifier_unit_assert.svh"

    localparam int DEPTH  = MAX_CLUSTERS * MAX_DIMS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int K_W    = $clog2(MAX_CLUSTERS);
    localparam int KCNT_W = $clog2(MAX_CLUSTERS + 1);
    localparam int POS_W  = $clog2(MAX_DIMS + 1);

    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // centroid table, one coordinate per entry, row per centroid
    logic [COORD_W-1:0] cent_mem [DEPTH];
    logic [COORD_W-1:0] rdata_reg;

    // control state
    ncc_state_t         state_reg, state_next;
    logic [CFG_W-1:0]   clusters_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               ovf_reg;
    logic               last_reg;
    logic [KCNT_W-1:0]  issue_k_reg;
    logic [KCNT_W-1:0]  scan_k_reg;
    logic [KCNT_W-1:0]  n_reg;
    logic               rd_vld_reg, mag_vld_reg, sq_vld_reg;
    logic               out_vld_reg;
    logic [DIST_W-1:0]  acc_reg [MAX_CLUSTERS];

    // datapath registers
    logic signed [COORD_W-1:0] coord_reg;
    logic [K_W-1:0]     rd_k_reg, mag_k_reg, sq_k_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [K_W-1:0]     best_k_reg;
    logic [DIST_W-1:0]  best_d_reg;
    logic [TOTAL_W-1:0] total_reg;
    out_item_t          out_reg;

    // handshake and sequencer decode
    logic in_acc;
    logic load_ok;
    logic point_in_range;
    logic issue_en;
    logic sweep_done;
    logic scan_en;
    logic scan_start;
    logic out_load;

    // shared datapath
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [COORD_W:0] diff;
    logic [MAG_W-1:0]        mag_next;
    logic [K_W-1:0]          acc_idx;
    logic [DIST_W-1:0]       acc_rd;
    logic [DIST_W:0]         acc_sum;
    logic [DIST_W-1:0]       acc_next;
    logic [TOTAL_W:0]        tot_sum;
    logic [TOTAL_W-1:0]      total_next;
    logic [KCNT_W-1:0]       n_clamp;

    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    assign in_acc         = in_valid && !in_stall;
    assign load_ok        = (32'(in_data.cluster_slot) < 32'(MAX_CLUSTERS))
                            && (32'(in_data.dim_slot) < 32'(MAX_DIMS));
    assign point_in_range = pos_reg < POS_W'(MAX_DIMS);
    assign sweep_done     = (issue_k_reg == KCNT_W'(MAX_CLUSTERS))
                            && !rd_vld_reg && !mag_vld_reg && !sq_vld_reg;

    // clusters_in_use of zero acts as one, above the table acts as the table size
    always_comb
    begin
        if (clusters_reg == '0)
            n_clamp = KCNT_W'(1);
        else if (32'(clusters_reg) > 32'(MAX_CLUSTERS))
            n_clamp = KCNT_W'(MAX_CLUSTERS);
        else
            n_clamp = KCNT_W'(clusters_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_data.command == CMD_POINT)
                begin
                    if (point_in_range)
                        state_next = ST_SWEEP;
                    else if (in_data.last_coord)
                        state_next = ST_SCAN;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_done)
                    state_next = last_reg ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_k_reg == n_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_vld_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall   = 1'b1;
        issue_en   = 1'b0;
        scan_en    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_SWEEP: issue_en = issue_k_reg < KCNT_W'(MAX_CLUSTERS);
            ST_SCAN:  scan_en  = scan_k_reg < n_reg;
            ST_DONE:  out_load = !out_vld_reg || !out_stall;
            default:  in_stall = 1'b1;
        endcase
    end

    assign scan_start = (state_next == ST_SCAN) && (state_reg != ST_SCAN);

    // table addressing: row = centroid, column = coordinate position
    assign rd_addr = ADDR_W'(32'(issue_k_reg[K_W-1:0]) * MAX_DIMS
                             + 32'(pos_reg));
    assign wr_addr = ADDR_W'(32'(in_data.cluster_slot) * MAX_DIMS
                             + 32'(in_data.dim_slot));

    always_ff @(posedge clk)
    begin
        if (in_acc && in_data.command == CMD_LOAD && load_ok)
            cent_mem[wr_addr] <= in_data.coord;
        if (issue_en)
            rdata_reg <= cent_mem[rd_addr];
    end

    // stage 1: magnitude of the coordinate difference
    assign diff     = (COORD_W+1)'(coord_reg) - (COORD_W+1)'(signed'(rdata_reg));
    assign mag_next = diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);

    // one accumulator read port shared by the accumulate stage and the scan
    assign acc_idx = (state_reg == ST_SCAN) ? scan_k_reg[K_W-1:0] : sq_k_reg;
    assign acc_rd  = acc_reg[acc_idx];

    // stage 3: accumulate with saturation
    assign acc_sum  = {1'b0, acc_rd} + (DIST_W+1)'(sq_reg);
    assign acc_next = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

    // scan: running total with saturation
    assign tot_sum    = {1'b0, total_reg} + (TOTAL_W+1)'(acc_rd);
    assign total_next = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            clusters_reg <= CLUSTERS_RESET;
            pos_reg      <= '0;
            ovf_reg      <= 1'b0;
            last_reg     <= 1'b0;
            issue_k_reg  <= '0;
            scan_k_reg   <= '0;
            n_reg        <= KCNT_W'(1);
            rd_vld_reg   <= 1'b0;
            mag_vld_reg  <= 1'b0;
            sq_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int k = 0; k < MAX_CLUSTERS; k++)
                acc_reg[k] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= issue_en;
            mag_vld_reg <= rd_vld_reg;
            sq_vld_reg  <= mag_vld_reg;
            out_vld_reg <= out_load || (out_vld_reg && out_stall);

            if (cfg_valid && cfg_ready)
                clusters_reg <= cfg_data;

            if (in_acc && in_data.command == CMD_POINT)
            begin
                last_reg    <= in_data.last_coord;
                issue_k_reg <= '0;
                if (!point_in_range)
                    ovf_reg <= 1'b1;
            end

            if (issue_en)
                issue_k_reg <= issue_k_reg + 1'b1;

            if (sq_vld_reg)
                acc_reg[sq_k_reg] <= acc_next;

            if (state_reg == ST_SWEEP && sweep_done)
                pos_reg <= pos_reg + 1'b1;

            if (scan_start)
            begin
                scan_k_reg <= '0;
                n_reg      <= n_clamp;
            end
            else if (scan_en)
                scan_k_reg <= scan_k_reg + 1'b1;

            // point finished: clear for the next one
            if (out_load)
            begin
                pos_reg <= '0;
                ovf_reg <= 1'b0;
                for (int k = 0; k < MAX_CLUSTERS; k++)
                    acc_reg[k] <= '0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc && in_data.command == CMD_POINT)
            coord_reg <= in_data.coord;

        rd_k_reg  <= issue_k_reg[K_W-1:0];
        mag_k_reg <= rd_k_reg;
        sq_k_reg  <= mag_k_reg;
        mag_reg   <= mag_next;
        sq_reg    <= SQ_W'(mag_reg) * SQ_W'(mag_reg);

        // strict less-than keeps the lowest index on ties
        if (scan_start)
        begin
            best_k_reg <= '0;
            best_d_reg <= DIST_MAX;
            total_reg  <= '0;
        end
        else if (scan_en)
        begin
            if (acc_rd < best_d_reg || scan_k_reg == '0)
            begin
                best_k_reg <= scan_k_reg[K_W-1:0];
                best_d_reg <= acc_rd;
            end
            total_reg <= total_next;
        end

        if (out_load)
        begin
            out_reg.nearest_cluster  <= OUT_K_W'(best_k_reg);
            out_reg.nearest_distance <= best_d_reg;
            out_reg.total_distance   <= total_reg;
            out_reg.dims_overflow    <= ovf_reg;
        end
    end

    // a result beat only appears after the scan has finished
    `NCC_ASSERT_NOW(a_result_after_scan, $rose(out_vld_reg), $past(state_reg == ST_DONE))
    // handing off a result leaves the point state cleared
    `NCC_ASSERT_NEXT(a_point_cleared, out_load, (pos_reg == '0) && !ovf_reg)
    // the nearest distance is part of the total, so never above it
    `NCC_ASSERT_NOW(a_best_within_total, state_reg == ST_DONE, TOTAL_W'(best_d_reg) <= total_reg)

endmodule
